>>> rtl/core/ppre_pkg.sv
// ----------------------------------------------------------------------------
// ppre_pkg
// Shared types, constants and the arctangent table of the planar pose and
// rate estimator.
// ----------------------------------------------------------------------------
package ppre_pkg;

  // Quaternion part width and its fraction bits (Q1.14)
  localparam int QUAT_BITS    = 16;
  localparam int QF           = QUAT_BITS - 2;
  // CORDIC iterations in vectoring mode
  localparam int CORDIC_STEPS = 16;
  // Shared divider: numerator magnitude width and denominator width
  localparam int DIV_NUM_W    = 33;
  localparam int DIV_DEN_W    = 40;
  // Square root steps over a 33 bit sum of squares
  localparam int ROOT_STEPS   = 17;

  localparam logic signed [35:0] PI_Q30   = 36'sd3373259426;
  localparam logic signed [35:0] HEAD_MAX = 36'sd25736;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_DLOAD,
    ST_DIV,
    ST_DSTORE,
    ST_PROD,
    ST_PRE,
    ST_ROT,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    DV_NORM,
    DV_VX,
    DV_VY,
    DV_RATE
  } div_sel_t;

  // Arctangent of 2^-i in Q2.30
  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    begin
      case (i)
        5'd0:    v = 32'd843314857;
        5'd1:    v = 32'd497837829;
        5'd2:    v = 32'd263043837;
        5'd3:    v = 32'd133525159;
        5'd4:    v = 32'd67021687;
        5'd5:    v = 32'd33543516;
        5'd6:    v = 32'd16775851;
        5'd7:    v = 32'd8388437;
        5'd8:    v = 32'd4194283;
        5'd9:    v = 32'd2097149;
        5'd31:   v = 32'd0;
        default: v = 32'd1 << (5'd30 - i);
      endcase
      atan_q30 = v;
    end
  endfunction

endpackage

>>> rtl/core/planar_pose_rate_estimator_core.sv
// ----------------------------------------------------------------------------
// planar_pose_rate_estimator_core
// Normalizes the attitude quaternion, finds yaw by CORDIC and forms x/y and
// yaw rates by finite difference over the elapsed ticks.
// ----------------------------------------------------------------------------
// One frame runs from the accepting edge to its registered result through
// a multiply-accumulate pass for the sum of squares, 17 square root steps,
// four normalizing divides and three rate divides (each a load state,
// 33 quotient steps and a store state), the quaternion products, the CORDIC
// (one pre-rotation and 16 steps) and a state that registers the result.
// A single 17x17 multiplier, a one-bit-a-cycle restoring divider and a
// CORDIC stage are reused under one sequencer. A zero tick count skips the
// rate divides. The block takes a new frame once the previous one is
// finished, even while its result is still stalled at the output; a frame
// that finishes while the output is still full waits in its last state.
module planar_pose_rate_estimator_core
  import ppre_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        frame_valid,
  output logic                        frame_stall,
  input  logic signed [31:0]          pos_x,
  input  logic signed [31:0]          pos_y,
  input  logic signed [QUAT_BITS-1:0] quat_w,
  input  logic signed [QUAT_BITS-1:0] quat_x,
  input  logic signed [QUAT_BITS-1:0] quat_y,
  input  logic signed [QUAT_BITS-1:0] quat_z,
  input  logic [39:0]                 elapsed_ticks,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic signed [31:0]          out_x,
  output logic signed [31:0]          out_y,
  output logic signed [31:0]          vel_x,
  output logic signed [31:0]          vel_y,
  output logic signed [15:0]          heading,
  output logic signed [31:0]          heading_rate,
  output logic                        rate_valid,
  output logic                        first_frame
);

  state_t   state, state_next;
  div_sel_t div_sel;

  // Latched request
  logic signed [31:0]          px, py;
  logic signed [QUAT_BITS-1:0] raw [4];
  logic [39:0]                 dt;

  // Kept frame state
  logic signed [31:0]          last_x, last_y;
  logic signed [QUAT_BITS-1:0] last_quat [4];
  logic                        acquired;

  // Working registers
  logic [5:0]                  cnt;
  logic [1:0]                  idx;
  logic [33:0]                 sum;
  logic [33:0]                 root_v, root_res, root_bit;
  logic signed [QUAT_BITS-1:0] q [4];
  logic signed [33:0]          s_acc, c_acc, zp;
  logic signed [33:0]          cx, cy;
  logic signed [35:0]          cz;
  logic signed [31:0]          vx, vy, rate;

  // Divider registers
  logic [DIV_NUM_W-1:0]        div_num, div_quo;
  logic [DIV_DEN_W-1:0]        div_den, div_rem;
  logic                        div_neg;

  // Shared multiplier
  logic signed [16:0]          mul_a, mul_b;
  logic signed [33:0]          mul_p;

  // Combinational helpers
  logic [33:0]                 root_trial;
  logic [DIV_DEN_W:0]          div_trial;
  logic signed [33:0]          div_src;
  logic [33:0]                 div_mag;
  logic signed [33:0]          cdx, cdy;
  logic signed [35:0]          catan;
  logic signed [35:0]          head_full;
  logic signed [15:0]          head_sat;
  logic signed [31:0]          sat_res;
  logic signed [QUAT_BITS-1:0] q_res;

  assign frame_stall = (state != ST_IDLE);

  // Select multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == ST_SQUARE) begin
      mul_a = {raw[cnt[1:0]][QUAT_BITS-1], raw[cnt[1:0]]};
      mul_b = mul_a;
    end else begin
      case (cnt[2:0])
        3'd0: begin mul_a = 17'(q[0]); mul_b = 17'(q[3]); end
        3'd1: begin mul_a = 17'(q[1]); mul_b = 17'(q[2]); end
        3'd2: begin mul_a = 17'(q[2]); mul_b = 17'(q[2]); end
        3'd3: begin mul_a = 17'(q[3]); mul_b = 17'(q[3]); end
        3'd4: begin mul_a = 17'(q[0]); mul_b = 17'(last_quat[3]); end
        3'd5: begin mul_a = 17'(q[1]); mul_b = 17'(last_quat[2]); end
        3'd6: begin mul_a = 17'(q[2]); mul_b = 17'(last_quat[1]); end
        default: begin mul_a = 17'(q[3]); mul_b = 17'(last_quat[0]); end
      endcase
    end
  end
  assign mul_p = mul_a * mul_b;

  // Square root step
  assign root_trial = root_res + root_bit;

  // Divider step
  assign div_trial = {div_rem, div_num[DIV_NUM_W-1]};

  // Pick divider numerator
  always_comb begin
    case (div_sel)
      DV_NORM: div_src = 34'(raw[idx]) <<< QF;
      DV_VX:   div_src = 34'(px) - 34'(last_x);
      DV_VY:   div_src = 34'(py) - 34'(last_y);
      // Twice zp floored to Q16.16
      default: div_src = zp >>> (2 * QF - 17);
    endcase
    div_mag = div_src[33] ? 34'(-div_src) : div_src;
  end

  // Shape divider quotient
  always_comb begin
    if (!div_neg) begin
      sat_res = (div_quo > 33'h07fffffff) ? 32'sh7fffffff : signed'(div_quo[31:0]);
      q_res   = signed'(div_quo[QUAT_BITS-1:0]);
    end else begin
      sat_res = (div_quo > 33'h080000000) ? 32'sh80000000 : -signed'(div_quo[31:0]);
      q_res   = -signed'(div_quo[QUAT_BITS-1:0]);
    end
  end

  // CORDIC step terms
  assign cdx   = cy >>> cnt[4:0];
  assign cdy   = cx >>> cnt[4:0];
  assign catan = 36'(atan_q30(cnt[4:0]));

  // Round and clamp heading
  always_comb begin
    head_full = (cz + 36'sd65536) >>> 17;
    if (head_full > HEAD_MAX) begin
      head_sat = 16'(HEAD_MAX);
    end else if (head_full < -HEAD_MAX) begin
      head_sat = 16'(-HEAD_MAX);
    end else begin
      head_sat = head_full[15:0];
    end
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequence the shared units
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (frame_valid) state_next = ST_SQUARE;
      ST_SQUARE: if (cnt == 6'd3) state_next = ST_ROOT;
      ST_ROOT:   if (cnt == 6'(ROOT_STEPS - 1)) state_next = ST_DLOAD;
      ST_DLOAD:  state_next = ST_DIV;
      ST_DIV:    if (cnt == 6'(DIV_NUM_W - 1)) state_next = ST_DSTORE;
      ST_DSTORE: begin
        if (div_sel == DV_NORM && idx != 2'd3) begin
          state_next = ST_DLOAD;
        end else if (div_sel == DV_NORM) begin
          state_next = ST_PROD;
        end else if (div_sel == DV_RATE) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_DLOAD;
        end
      end
      ST_PROD:   if (cnt == 6'd7) state_next = ST_PRE;
      ST_PRE:    state_next = ST_ROT;
      ST_ROT: begin
        if (cnt == 6'(CORDIC_STEPS - 1)) begin
          state_next = (dt != '0) ? ST_DLOAD : ST_DONE;
        end
      end
      ST_DONE:   if (!result_valid || !result_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Advance datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      last_x       <= '0;
      last_y       <= '0;
      last_quat[0] <= QUAT_BITS'(1) << QF;
      last_quat[1] <= '0;
      last_quat[2] <= '0;
      last_quat[3] <= '0;
      acquired     <= 1'b0;
      result_valid <= 1'b0;
      cnt          <= '0;
      idx          <= '0;
      div_sel      <= DV_NORM;
    end else begin
      // Drop a taken result unless a new one replaces it
      if (result_valid && !result_stall && state != ST_DONE) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (frame_valid) begin
            px     <= pos_x;
            py     <= pos_y;
            raw[0] <= quat_w;
            raw[1] <= quat_x;
            raw[2] <= quat_y;
            raw[3] <= quat_z;
            dt     <= elapsed_ticks;
            sum    <= '0;
            cnt    <= '0;
          end
        end
        ST_SQUARE: begin
          sum <= sum + unsigned'(mul_p);
          if (cnt == 6'd3) begin
            cnt      <= '0;
            root_res <= '0;
            root_bit <= 34'd1 << 32;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        ST_ROOT: begin
          if (root_trial <= ((cnt == 6'd0) ? sum : root_v)) begin
            root_v   <= ((cnt == 6'd0) ? sum : root_v) - root_trial;
            root_res <= (root_res >> 1) + root_bit;
          end else begin
            root_res <= root_res >> 1;
            if (cnt == 6'd0) begin
              root_v <= sum;
            end
          end
          root_bit <= root_bit >> 2;
          if (cnt == 6'(ROOT_STEPS - 1)) begin
            cnt     <= '0;
            idx     <= '0;
            div_sel <= DV_NORM;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        ST_DLOAD: begin
          div_num <= div_mag[DIV_NUM_W-1:0];
          div_neg <= div_src[33];
          div_den <= (div_sel == DV_NORM) ? DIV_DEN_W'(root_res) : dt;
          div_rem <= '0;
          div_quo <= '0;
          cnt     <= '0;
        end
        ST_DIV: begin
          if (div_trial >= {1'b0, div_den}) begin
            div_rem <= DIV_DEN_W'(div_trial - {1'b0, div_den});
            div_quo <= {div_quo[DIV_NUM_W-2:0], 1'b1};
          end else begin
            div_rem <= div_trial[DIV_DEN_W-1:0];
            div_quo <= {div_quo[DIV_NUM_W-2:0], 1'b0};
          end
          div_num <= div_num << 1;
          cnt     <= (cnt == 6'(DIV_NUM_W - 1)) ? 6'd0 : cnt + 6'd1;
        end
        ST_DSTORE: begin
          case (div_sel)
            DV_NORM: begin
              // A zero norm gives an all zero quaternion
              q[idx] <= (root_res == '0) ? '0 : q_res;
              idx    <= idx + 2'd1;
            end
            DV_VX: begin
              vx      <= sat_res;
              div_sel <= DV_VY;
            end
            DV_VY: begin
              vy      <= sat_res;
              div_sel <= DV_RATE;
            end
            default: rate <= sat_res;
          endcase
          cnt <= '0;
        end
        ST_PROD: begin
          case (cnt[2:0])
            3'd0:    s_acc <= mul_p;
            3'd1:    s_acc <= s_acc + mul_p;
            3'd2:    c_acc <= mul_p;
            3'd3:    c_acc <= c_acc + mul_p;
            3'd4:    zp    <= -mul_p;
            3'd5:    zp    <= zp - mul_p;
            default: zp    <= zp + mul_p;
          endcase
          cnt <= (cnt == 6'd7) ? 6'd0 : cnt + 6'd1;
        end
        ST_PRE: begin
          // Pre-rotate the left half plane by pi
          if ((34'sd1 <<< (2 * QF)) - (c_acc <<< 1) < 0) begin
            cx <= (c_acc <<< 1) - (34'sd1 <<< (2 * QF));
            cy <= -(s_acc <<< 1);
            cz <= (s_acc < 0) ? -PI_Q30 : PI_Q30;
          end else begin
            cx <= (34'sd1 <<< (2 * QF)) - (c_acc <<< 1);
            cy <= s_acc <<< 1;
            cz <= '0;
          end
          cnt <= '0;
        end
        ST_ROT: begin
          if (cy < 0) begin
            cx <= cx - cdx;
            cy <= cy + cdy;
            cz <= cz - catan;
          end else begin
            cx <= cx + cdx;
            cy <= cy - cdy;
            cz <= cz + catan;
          end
          if (cnt == 6'(CORDIC_STEPS - 1)) begin
            cnt     <= '0;
            div_sel <= DV_VX;
            if (dt == '0) begin
              vx   <= '0;
              vy   <= '0;
              rate <= '0;
            end
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        ST_DONE: begin
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            out_x        <= px;
            out_y        <= py;
            vel_x        <= vx;
            vel_y        <= vy;
            heading      <= head_sat;
            heading_rate <= rate;
            rate_valid   <= (dt != '0);
            first_frame  <= !acquired;
            last_x       <= px;
            last_y       <= py;
            last_quat[0] <= q[0];
            last_quat[1] <= q[1];
            last_quat[2] <= q[2];
            last_quat[3] <= q[3];
            acquired     <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> verif/tb_planar_pose_rate_estimator_core.sv
// ----------------------------------------------------------------------------
// tb_planar_pose_rate_estimator_core
// Sends tracked-body frames through the pose and rate estimator and compares
// every result with a fixed-point predictor of heading, velocity and yaw rate
// that keeps its own copy of the previous position and attitude.
// ----------------------------------------------------------------------------

class pose_scoreboard;
  typedef struct packed {
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [15:0] head;
    logic signed [31:0] hrate;
    logic               rvalid;
    logic               first;
  } pose_t;

  pose_t pending[$];
  int errors;
  longint prev_x, prev_y;
  longint prev_q[4];
  bit acquired;

  function void clear();
    pending.delete();
    errors = 0;
    prev_x = 0;
    prev_y = 0;
    prev_q[0] = 64'sd1 <<< ppre_pkg::QF;
    prev_q[1] = 0;
    prev_q[2] = 0;
    prev_q[3] = 0;
    acquired = 0;
  endfunction

  static function longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  static function longint div_toward_zero(longint num, longint unsigned den);
    longint unsigned m;
    longint unsigned qt;
    m = (num < 0) ? longint'(-num) : num;
    qt = m / den;
    return (num < 0) ? -longint'(qt) : longint'(qt);
  endfunction

  static function longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  static function longint yaw_atan2(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? longint'(ppre_pkg::PI_Q30) : -longint'(ppre_pkg::PI_Q30);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < ppre_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y < 0) begin
        x -= dx; y += dy; z -= longint'(ppre_pkg::atan_q30(i[4:0]));
      end else begin
        x += dx; y -= dy; z += longint'(ppre_pkg::atan_q30(i[4:0]));
      end
    end
    return z;
  endfunction

  // Note an accepted request and queue its expected result
  function void note_frame(logic signed [31:0] px, logic signed [31:0] py,
                           logic signed [15:0] qw, logic signed [15:0] qx,
                           logic signed [15:0] qy, logic signed [15:0] qz,
                           logic [39:0] ticks);
    longint rawq[4], q[4];
    longint unsigned sum, n, m;
    longint s, c, hd, zp;
    int sh;
    pose_t e;
    rawq[0] = qw; rawq[1] = qx; rawq[2] = qy; rawq[3] = qz;
    sum = 0;
    for (int i = 0; i < 4; i++) sum += longint'(rawq[i] * rawq[i]);
    n = int_sqrt(sum);
    for (int i = 0; i < 4; i++) begin
      if (n == 0) q[i] = 0;
      else begin
        m = (rawq[i] < 0) ? -rawq[i] : rawq[i];
        m = (m << ppre_pkg::QF) / n;
        q[i] = (rawq[i] < 0) ? -longint'(m) : longint'(m);
      end
    end
    sh = (2 * ppre_pkg::QF > 28) ? 2 * ppre_pkg::QF - 28 : 0;
    s = 2 * (q[0] * q[3] + q[1] * q[2]);
    c = (64'sd1 <<< (2 * ppre_pkg::QF)) - 2 * (q[2] * q[2] + q[3] * q[3]);
    hd = (yaw_atan2(s >>> sh, c >>> sh) + (64'sd1 <<< 16)) >>> 17;
    if (hd > 25736) hd = 25736;
    if (hd < -25736) hd = -25736;
    e.ox = px;
    e.oy = py;
    e.head = hd[15:0];
    e.rvalid = (ticks != 0);
    e.first = !acquired;
    e.vx = 0; e.vy = 0; e.hrate = 0;
    if (ticks != 0) begin
      e.vx = 32'(clamp32(div_toward_zero(longint'(px) - prev_x, ticks)));
      e.vy = 32'(clamp32(div_toward_zero(longint'(py) - prev_y, ticks)));
      zp = -q[0] * prev_q[3] - q[1] * prev_q[2] + q[2] * prev_q[1] + q[3] * prev_q[0];
      e.hrate = 32'(clamp32(div_toward_zero((2 * zp) >>> (2 * ppre_pkg::QF - 16),
                                            ticks)));
    end
    pending.push_back(e);
    prev_x = px;
    prev_y = py;
    for (int i = 0; i < 4; i++) prev_q[i] = q[i];
    acquired = 1;
  endfunction

  // Compare one accepted result with the oldest expectation
  function void check_result(pose_t a);
    pose_t e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %h", $time, a);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (a.ox !== e.ox) begin
      $display("%0t: out_x exp %0d got %0d", $time, e.ox, a.ox); errors++;
    end
    if (a.oy !== e.oy) begin
      $display("%0t: out_y exp %0d got %0d", $time, e.oy, a.oy); errors++;
    end
    if (a.vx !== e.vx) begin
      $display("%0t: vel_x exp %0d got %0d", $time, e.vx, a.vx); errors++;
    end
    if (a.vy !== e.vy) begin
      $display("%0t: vel_y exp %0d got %0d", $time, e.vy, a.vy); errors++;
    end
    if (a.head !== e.head) begin
      $display("%0t: heading exp %0d got %0d", $time, e.head, a.head); errors++;
    end
    if (a.hrate !== e.hrate) begin
      $display("%0t: heading_rate exp %0d got %0d", $time, e.hrate, a.hrate); errors++;
    end
    if (a.rvalid !== e.rvalid) begin
      $display("%0t: rate_valid exp %0b got %0b", $time, e.rvalid, a.rvalid); errors++;
    end
    if (a.first !== e.first) begin
      $display("%0t: first_frame exp %0b got %0b", $time, e.first, a.first); errors++;
    end
  endfunction
endclass

module tb_planar_pose_rate_estimator_core;
  import ppre_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic frame_valid = 1'b0;
  logic frame_stall;
  logic signed [31:0] pos_x = '0;
  logic signed [31:0] pos_y = '0;
  logic signed [QUAT_BITS-1:0] quat_w = '0;
  logic signed [QUAT_BITS-1:0] quat_x = '0;
  logic signed [QUAT_BITS-1:0] quat_y = '0;
  logic signed [QUAT_BITS-1:0] quat_z = '0;
  logic [39:0] elapsed_ticks = '0;
  logic result_valid;
  logic result_stall = 1'b1;
  logic signed [31:0] out_x, out_y, vel_x, vel_y, heading_rate;
  logic signed [15:0] heading;
  logic rate_valid, first_frame;

  pose_scoreboard board;
  int idle_cycles = 0;

  planar_pose_rate_estimator_core dut (.*);

  always #1 clk = ~clk;

  // Watch for a stuck handshake
  always @(posedge clk) begin
    if ((frame_valid && !frame_stall) || (result_valid && !result_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_planar_pose_rate_estimator_core NOT OK");
      $finish;
    end
  end

  // Check each accepted result
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall)
        board.check_result({out_x, out_y, vel_x, vel_y, heading, heading_rate,
                            rate_valid, first_frame});
    end
  end

  initial begin : stall_gen
    int gap;
    @(posedge clk);
    while (1) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
        result_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      result_stall <= 1'b0;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
    end
  end

  // Present one request and hold it until accepted
  task automatic send_frame(logic signed [31:0] px, logic signed [31:0] py,
                            logic signed [15:0] qw, logic signed [15:0] qx,
                            logic signed [15:0] qy, logic signed [15:0] qz,
                            logic [39:0] ticks);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
    // Drop the request line while idling
    if (gap != 0) begin
      frame_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    frame_valid <= 1'b1;
    pos_x <= px; pos_y <= py;
    quat_w <= qw; quat_x <= qx; quat_y <= qy; quat_z <= qz;
    elapsed_ticks <= ticks;
    @(posedge clk);
    while (frame_stall) @(posedge clk);
    board.note_frame(px, py, qw, qx, qy, qz, ticks);
  endtask

  function automatic logic [39:0] rand_ticks();
    case ($urandom_range(0, 5))
      0: return 40'd0;
      1: return 40'({$urandom, $urandom});
      2: return 40'd1;
      default: return 40'($urandom_range(1, 1000));
    endcase
  endfunction

  function automatic logic [15:0] rand_part();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  initial begin : stimulus
    logic signed [31:0] px, py;
    int settle;
    board = new();
    board.clear();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset frame, zero ticks, zero and extreme quaternions
    send_frame(32'sd65536, -32'sd65536, 16'sd16384, '0, '0, '0, 40'd1);
    send_frame(32'sd65536, -32'sd65536, 16'sd16384, '0, '0, 16'sd100, 40'd0);
    send_frame('0, '0, '0, '0, '0, '0, 40'd10);
    send_frame(32'h7FFFFFFF, 32'h80000000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 40'd1);
    send_frame(32'h80000000, 32'h7FFFFFFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 40'd1);
    send_frame('0, '0, 16'sd11585, '0, '0, 16'sd11585, 40'hFF_FFFF_FFFF);
    send_frame('0, '0, -16'sd11585, '0, '0, 16'sd11585, 40'd3);
    send_frame(32'sd5, -32'sd5, '0, '0, '0, 16'sd16384, 40'd2);
    send_frame(32'sd5, -32'sd5, '0, '0, '0, -16'sd16384, 40'd1);
    send_frame(32'sd5, -32'sd5, '0, 16'sd16384, '0, '0, 40'd1);
    send_frame(32'sd5, -32'sd5, '0, '0, 16'sd16384, '0, 40'd1);
    send_frame(32'sd5, -32'sd5, -16'sd16384, '0, '0, '0, 40'd1);
    send_frame(32'h80000000, 32'h80000000, '0, 16'h7FFF, 16'h8000, '0, 40'd1);
    frame_valid <= 1'b0;

    // Hold off until the block has drained
    while (board.pending.size() != 0) @(posedge clk);

    // Random: mostly smooth tracks with occasional jumps
    px = 0; py = 0;
    for (int k = 0; k < 750; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        px = $urandom; py = $urandom;
      end else begin
        px = px + $signed($urandom_range(0, 200000)) - 100000;
        py = py + $signed($urandom_range(0, 200000)) - 100000;
      end
      send_frame(px, py, rand_part(), rand_part(), rand_part(), rand_part(), rand_ticks());
    end
    frame_valid <= 1'b0;

    // Drain, then allow the tail latency
    while (board.pending.size() != 0) @(posedge clk);
    settle = 0;
    while (settle < 400) begin
      @(posedge clk);
      settle++;
    end
    if (board.errors == 0 && board.pending.size() == 0)
      $display("tb_planar_pose_rate_estimator_core OK");
    else
      $display("tb_planar_pose_rate_estimator_core NOT OK");
    $finish;
  end
endmodule

>>> sim.f
rtl/core/ppre_pkg.sv
rtl/core/planar_pose_rate_estimator_core.sv
verif/tb_planar_pose_rate_estimator_core.sv
